// File: design/http_chunked_encoder_defines.svh
// Assertion macros shared by the checkers of the chunked encoder.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef HTTP_CHUNKED_ENCODER_DEFINES_SVH
`define HTTP_CHUNKED_ENCODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hce_pkg.sv
// Shared constants, types and helper functions of the chunked encoder.
// Depends on nothing; the encoder top, buffer and sequencer refer to it by scoped names.
package hce_pkg;

    localparam int HCE_MAX_CHUNK = 53;
    localparam int HCE_ADDR_W    = $clog2(HCE_MAX_CHUNK);
    localparam int HCE_LEN_W     = 6;

    localparam logic [HCE_LEN_W-1:0] HCE_RESET_CHUNK = 6'd50;
    localparam logic [HCE_LEN_W-1:0] HCE_MAX_LEN     = 6'd53;
    localparam logic [HCE_LEN_W-1:0] HCE_HEX_TWO     = 6'd16;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    localparam logic [7:0] ASCII_CR   = 8'h0d;
    localparam logic [7:0] ASCII_LF   = 8'h0a;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam int ST_W = 14;

    typedef enum logic [ST_W-1:0] {
        ST_IDLE = 14'b00000000000001,
        ST_HEXH = 14'b00000000000010,
        ST_HEXL = 14'b00000000000100,
        ST_CR1  = 14'b00000000001000,
        ST_LF1  = 14'b00000000010000,
        ST_RD   = 14'b00000000100000,
        ST_DATA = 14'b00000001000000,
        ST_CR2  = 14'b00000010000000,
        ST_LF2  = 14'b00000100000000,
        ST_TZ   = 14'b00001000000000,
        ST_TCR1 = 14'b00010000000000,
        ST_TLF1 = 14'b00100000000000,
        ST_TCR2 = 14'b01000000000000,
        ST_TLF2 = 14'b10000000000000
    } t_state;

    // Request from the front end to start one output run.
    typedef struct packed {
        logic                 start;
        logic                 has_chunk;
        logic                 term;
        logic [HCE_LEN_W-1:0] len;
    } t_emit_cmd;

    // Read request from the framing sequencer to the chunk buffer.
    typedef struct packed {
        logic                  en;
        logic [HCE_ADDR_W-1:0] addr;
    } t_rd_req;

    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h61 + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: design/hce_stream_if.sv
// Valid/ready stream interfaces for the input and output channels.
// Depends on nothing.
interface hce_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface hce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: design/http_chunked_encoder.sv
// Top level of the HTTP chunked transfer encoder.
// Depends on hce_pkg, hce_stream_if, hce_buffer and hce_sequencer.
//
// Usage: body bytes (action 0) and end-of-message marks (action 1) arrive on
// i_in, a valid/ready channel; each transfer is one item. The encoded stream
// leaves on o_out one byte per transfer, with last set on the final byte of
// the run that one input item causes.
// A body byte that does not complete a chunk is only written to the buffer
// and gives no output. An item that starts a run holds i_in.ready low until
// the run's last byte is loaded into the output register: each data byte
// needs a buffer read (ST_RD), then a load of the registered read data
// (ST_DATA); each framing byte needs one load, and a stall delays any load.
// The chunk buffer has a single read port, so data bytes are read one by one.
// The output register decouples the two sides: the next input item is taken
// while the final byte of a run still waits at o_out.
// When the receiver stalls (o_out.ready low) the current byte holds and the
// sequencer waits; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the chunk, drops any pending
// output byte and sets chunk_size to 50. Buffer contents are not cleared;
// entries are only read after they are written in the same chunk. The user
// must write chunk_size (i_cfg_we/i_cfg_wdata) only while the block is idle;
// the block does not enforce this. Zero counts as one, values above 53 as 53.
module http_chunked_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hce_in_if.sink                        i_in,
    hce_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [hce_pkg::HCE_LEN_W-1:0] i_cfg_wdata
);

    logic [hce_pkg::HCE_LEN_W-1:0] r_chunk_size;
    logic [hce_pkg::HCE_LEN_W-1:0] r_fill, n_fill;
    logic [hce_pkg::HCE_LEN_W-1:0] w_size;
    logic [hce_pkg::HCE_LEN_W-1:0] w_fill_inc;
    logic                          w_acc;
    logic                          w_is_byte;
    logic                          w_full;
    logic                          w_busy;
    logic [7:0]                    w_rdata;
    hce_pkg::t_emit_cmd            w_cmd;
    hce_pkg::t_rd_req              w_rd;

    // Clamp the configured size into the legal range of one to the buffer depth.
    always_comb begin
        if (r_chunk_size == '0) begin
            w_size = 6'd1;
        end else if (r_chunk_size > hce_pkg::HCE_MAX_LEN) begin
            w_size = hce_pkg::HCE_MAX_LEN;
        end else begin
            w_size = r_chunk_size;
        end
    end

    // Items are taken only while no run is in progress; the buffer write at
    // acceptance is therefore always done before the sequencer reads it back.
    assign i_in.ready = !w_busy;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_is_byte  = (i_in.action == hce_pkg::ACTION_BYTE);
    assign w_fill_inc = hce_pkg::HCE_LEN_W'(r_fill + 6'd1);

    // A lowered chunk size leaves more bytes buffered than the size; the
    // compare still fires and all buffered bytes go out as one chunk.
    assign w_full = (w_fill_inc >= w_size);

    always_comb begin
        w_cmd.start     = w_acc && (!w_is_byte || w_full);
        w_cmd.has_chunk = w_is_byte || (r_fill != '0);
        w_cmd.term      = !w_is_byte;
        w_cmd.len       = w_is_byte ? w_fill_inc : r_fill;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_acc) begin
            n_fill = w_cmd.start ? '0 : w_fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_chunk_size <= hce_pkg::HCE_RESET_CHUNK;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_we) begin
                r_chunk_size <= i_cfg_wdata;
            end
        end
    end

    hce_buffer u_buffer (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_is_byte),
        .i_waddr (r_fill[hce_pkg::HCE_ADDR_W-1:0]),
        .i_wdata (i_in.data_byte),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    hce_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_rdata (w_rdata),
        .o_rd    (w_rd),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

endmodule

// File: design/hce_buffer.sv
// Chunk data buffer: one write port, one read port, registered read data.
// Depends on hce_pkg.
module hce_buffer (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [hce_pkg::HCE_ADDR_W-1:0] i_waddr,
    input  logic [7:0]                     i_wdata,
    input  hce_pkg::t_rd_req               i_rd,
    output logic [7:0]                     o_rdata
);

    logic [7:0] r_mem [hce_pkg::HCE_MAX_CHUNK];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read, so the sequencer may stall on it.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/hce_sequencer.sv
// Framing sequencer: walks the hex length, CR LF, buffered data, CR LF and
// the terminator, and owns the output register. Depends on hce_pkg, hce_out_if.
module hce_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hce_pkg::t_emit_cmd    i_cmd,
    input  logic [7:0]            i_rdata,
    output hce_pkg::t_rd_req      o_rd,
    output logic                  o_busy,
    hce_out_if.source             o_out
);

    hce_pkg::t_state                r_state, n_state;
    logic [hce_pkg::HCE_ADDR_W-1:0] r_idx, n_idx;
    logic [hce_pkg::HCE_LEN_W-1:0]  r_len, n_len;
    logic                           r_term, n_term;
    logic                           r_ov, n_ov;
    logic [7:0]                     r_byte, n_byte;
    logic                           r_last, n_last;
    logic                           w_load;
    logic [hce_pkg::HCE_LEN_W-1:0]  w_last_idx;

    // The output slot can take a new byte when empty or being drained.
    assign w_load     = !r_ov || o_out.ready;
    assign w_last_idx = hce_pkg::HCE_LEN_W'(r_len - 6'd1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        n_term  = r_term;
        n_ov    = w_load ? 1'b0 : r_ov;
        n_byte  = r_byte;
        n_last  = r_last;
        o_rd.en   = 1'b0;
        o_rd.addr = r_idx;

        case (r_state)
            hce_pkg::ST_IDLE: begin
                if (i_cmd.start) begin
                    n_len  = i_cmd.len;
                    n_term = i_cmd.term;
                    n_idx  = '0;
                    if (!i_cmd.has_chunk) begin
                        n_state = hce_pkg::ST_TZ;
                    end else if (i_cmd.len >= hce_pkg::HCE_HEX_TWO) begin
                        n_state = hce_pkg::ST_HEXH;
                    end else begin
                        n_state = hce_pkg::ST_HEXL;
                    end
                end
            end
            hce_pkg::ST_HEXH: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::hex_ascii({2'b00, r_len[5:4]});
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_HEXL;
                end
            end
            hce_pkg::ST_HEXL: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::hex_ascii(r_len[3:0]);
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_CR1;
                end
            end
            hce_pkg::ST_CR1: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_CR;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_LF1;
                end
            end
            hce_pkg::ST_LF1: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_LF;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_RD;
                end
            end
            hce_pkg::ST_RD: begin
                o_rd.en = 1'b1;
                n_state = hce_pkg::ST_DATA;
            end
            hce_pkg::ST_DATA: begin
                if (w_load) begin
                    n_ov   = 1'b1;
                    n_byte = i_rdata;
                    n_last = 1'b0;
                    if (r_idx == w_last_idx) begin
                        n_state = hce_pkg::ST_CR2;
                    end else begin
                        n_idx   = hce_pkg::HCE_ADDR_W'(r_idx + 6'd1);
                        n_state = hce_pkg::ST_RD;
                    end
                end
            end
            hce_pkg::ST_CR2: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_CR;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_LF2;
                end
            end
            hce_pkg::ST_LF2: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_LF;
                    n_last  = !r_term;
                    n_state = r_term ? hce_pkg::ST_TZ : hce_pkg::ST_IDLE;
                end
            end
            hce_pkg::ST_TZ: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_ZERO;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_TCR1;
                end
            end
            hce_pkg::ST_TCR1: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_CR;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_TLF1;
                end
            end
            hce_pkg::ST_TLF1: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_LF;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_TCR2;
                end
            end
            hce_pkg::ST_TCR2: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_CR;
                    n_last  = 1'b0;
                    n_state = hce_pkg::ST_TLF2;
                end
            end
            hce_pkg::ST_TLF2: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_byte  = hce_pkg::ASCII_LF;
                    n_last  = 1'b1;
                    n_state = hce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hce_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_term <= n_term;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_busy         = (r_state != hce_pkg::ST_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

// File: design/hce_checker.sv
// Port-level checker for the chunked encoder, bound to the top level.
// Depends on http_chunked_encoder_defines.svh and http_chunked_encoder.
`include "http_chunked_encoder_defines.svh"

module hce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A pending output byte is held until its transfer.
    `HCE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output byte dropped")

    `HCE_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready,
        $stable(i_out_byte) && $stable(i_out_last), "stalled output changed")

    // An end-of-message mark always starts a run, so input closes next cycle.
    `HCE_ASSERT_NEXT(a_end_busy, i_in_valid && i_in_ready && i_in_action,
        !i_in_ready, "end of message produced no run")

    // While input is open, only the closing byte of a run can still wait.
    `HCE_ASSERT_SAME(a_idle_last, i_in_ready && i_out_valid, i_out_last,
        "input open in the middle of a run")

endmodule

bind http_chunked_encoder hce_checker u_hce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

// File: sim/http_chunked_encoder_tb.sv
// Self-checking testbench for the HTTP chunked transfer encoder.
// Depends on hce_pkg, hce_stream_if and the http_chunked_encoder RTL.
// A directed table is walked first, then random messages under several chunk sizes.
module http_chunked_encoder_tb;

    // A correct run stays far below this time.
    localparam int LIMIT_TIME    = 5_000_000;
    // Cycles to let pass before a register write. They cover a body byte still
    // being taken after the last expected output byte has arrived.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    // The receiver holds off once for this long, after this many input transfers.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_ITEM  = 180;
    localparam int IDLE_PCT      = 14;
    localparam int N_DIR         = 21;
    localparam int N_PHASE       = 10;
    // Input transfers offered per random phase; the last message may run over.
    localparam int PHASE_ITEMS   = 28;

    // One byte of the encoded stream as it should leave the block.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_enc_byte;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // One row of the directed table. A row with fixed_len zero is checked
    // against the predictor; otherwise fixed_bytes holds the whole output run,
    // right-aligned, first byte at the top.
    typedef struct packed {
        t_row_kind                     kind;
        logic [hce_pkg::HCE_LEN_W-1:0] size;
        logic                          action;
        logic [7:0]                    data;
        logic [3:0]                    fixed_len;
        logic [63:0]                   fixed_bytes;
    } t_dir_row;

    localparam logic [63:0] TERM_RUN = 64'("0\r\n\r\n");
    localparam logic [63:0] ONE_FF   = 64'({"1\r\n", 8'hff, "\r\n"});
    localparam logic [63:0] ONE_00   = 64'({"1\r\n", 8'h00, "\r\n"});
    localparam logic [63:0] ONE_5A   = 64'({"1\r\n", 8'h5a, "\r\n"});

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hce_pkg::HCE_LEN_W-1:0] i_cfg_wdata;

    hce_in_if  in_if ();
    hce_out_if out_if ();

    http_chunked_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the partial chunk, its fill level and the chunk size
    // register as last written.
    logic [7:0]                    body_buf [hce_pkg::HCE_MAX_CHUNK];
    int                            body_fill;
    logic [hce_pkg::HCE_LEN_W-1:0] chunk_cfg;

    t_enc_byte run_q[$];      // output run of the input transfer just taken
    t_enc_byte pending_q[$];  // encoded bytes still owed by the block

    int fault_cnt   = 0;
    int items_taken = 0;
    bit calm        = 1'b0;   // both sides stop idling while this is set
    bit hold_done   = 1'b0;

    // The directed table. It covers the empty message, a data byte sent along
    // with the end mark, chunk sizes one, zero and above the maximum, and a
    // chunk size lowered below the bytes already buffered, which flushes all
    // of them as one chunk on the next body byte.
    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_END,  8'h00, 4'd5, TERM_RUN},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h80, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_END,  8'hff, 4'd0, 64'd0},
        '{ROW_CFG,  6'd1,  hce_pkg::ACTION_BYTE, 8'h00, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'hff, 4'd6, ONE_FF},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h00, 4'd6, ONE_00},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_END,  8'ha5, 4'd5, TERM_RUN},
        '{ROW_CFG,  6'd0,  hce_pkg::ACTION_BYTE, 8'h00, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h5a, 4'd6, ONE_5A},
        '{ROW_CFG,  6'd5,  hce_pkg::ACTION_BYTE, 8'h00, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h01, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h02, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h03, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h04, 4'd0, 64'd0},
        '{ROW_CFG,  6'd2,  hce_pkg::ACTION_BYTE, 8'h00, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h05, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h0d, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_END,  8'h00, 4'd0, 64'd0},
        '{ROW_CFG,  6'd63, hce_pkg::ACTION_BYTE, 8'h00, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_BYTE, 8'h7f, 4'd0, 64'd0},
        '{ROW_ITEM, 6'd0,  hce_pkg::ACTION_END,  8'h00, 4'd0, 64'd0}
    };

    // Zero counts as one and anything above the buffer depth as the depth.
    function automatic int eff_size(input logic [hce_pkg::HCE_LEN_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > hce_pkg::HCE_MAX_CHUNK) begin
            return hce_pkg::HCE_MAX_CHUNK;
        end
        return int'(v);
    endfunction

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10) begin
            return hce_pkg::ASCII_ZERO + 8'(nib);
        end
        return 8'("a") + 8'(nib - 10);
    endfunction

    function automatic void put_code(input logic [7:0] c);
        run_q.push_back('{code: c, last: 1'b0});
    endfunction

    // Length in lower-case hex without leading zeros, CR LF, the data, CR LF.
    function automatic void frame_chunk();
        if (body_fill >= 16) begin
            put_code(hex_char(body_fill / 16));
        end
        put_code(hex_char(body_fill % 16));
        put_code(hce_pkg::ASCII_CR);
        put_code(hce_pkg::ASCII_LF);
        for (int k = 0; k < body_fill; k++) begin
            put_code(body_buf[k]);
        end
        put_code(hce_pkg::ASCII_CR);
        put_code(hce_pkg::ASCII_LF);
        body_fill = 0;
    endfunction

    // Works out the output run that one input transfer causes and advances
    // the predictor state.
    function automatic void encode_item(input logic act, input logic [7:0] dat);
        run_q.delete();
        if (act == hce_pkg::ACTION_BYTE) begin
            if (body_fill < hce_pkg::HCE_MAX_CHUNK) begin
                body_buf[body_fill] = dat;
                body_fill++;
            end
            if (body_fill >= eff_size(chunk_cfg)) begin
                frame_chunk();
            end
        end else begin
            // The data byte is ignored; any partial chunk goes out first.
            if (body_fill > 0) begin
                frame_chunk();
            end
            put_code(hce_pkg::ASCII_ZERO);
            put_code(hce_pkg::ASCII_CR);
            put_code(hce_pkg::ASCII_LF);
            put_code(hce_pkg::ASCII_CR);
            put_code(hce_pkg::ASCII_LF);
            body_fill = 0;
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Offers one item, called at a falling edge, and returns at the falling
    // edge after its transfer. The expected bytes are queued at the transfer.
    task automatic send_item(input logic act, input logic [7:0] dat,
                             input logic [3:0] fixed_len, input logic [63:0] fixed_bytes);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.action    = act;
        in_if.data_byte = dat;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        items_taken++;
        encode_item(act, dat);
        if (fixed_len != 4'd0) begin
            for (int k = 0; k < int'(fixed_len); k++) begin
                pending_q.push_back('{code: fixed_bytes[8 * (int'(fixed_len) - 1 - k) +: 8],
                                      last: (k == int'(fixed_len) - 1)});
            end
        end else begin
            foreach (run_q[k]) begin
                pending_q.push_back(run_q[k]);
            end
        end
        @(negedge i_clk);
    endtask

    // Writes the chunk size once the block has gone quiet.
    task automatic set_chunk(input logic [hce_pkg::HCE_LEN_W-1:0] v);
        in_if.valid = 1'b0;
        while (pending_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        chunk_cfg = v;
    endtask

    // Stimulus: reset, the directed table, then one random phase per chunk size.
    initial begin
        logic [hce_pkg::HCE_LEN_W-1:0] sizes [N_PHASE];
        int eff;
        int budget;
        int sent;
        int len;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.action    = hce_pkg::ACTION_BYTE;
        in_if.data_byte = 8'h00;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        body_fill       = 0;
        chunk_cfg       = hce_pkg::HCE_RESET_CHUNK;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                set_chunk(dir_rows[r].size);
            end else begin
                send_item(dir_rows[r].action, dir_rows[r].data,
                          dir_rows[r].fixed_len, dir_rows[r].fixed_bytes);
            end
        end

        // The reset size and the extremes first, then ordinary sizes, some around
        // the point where the length takes a second hex digit, then two random sizes.
        sizes = '{6'd50, 6'd63, 6'd53, 6'd0, 6'd1, 6'd16, 6'd15, 6'd2, 6'd0, 6'd0};
        sizes[8] = hce_pkg::HCE_LEN_W'($urandom_range(3, 52));
        sizes[9] = hce_pkg::HCE_LEN_W'($urandom_range(54, 63));

        for (int p = 0; p < N_PHASE; p++) begin
            set_chunk(sizes[p]);
            eff    = eff_size(sizes[p]);
            budget = PHASE_ITEMS;
            calm   = (p == 4 || p == 5);
            sent   = 0;
            while (sent < budget) begin
                if ($urandom_range(99) < 8) begin
                    // A bare end mark, often with a stray data byte.
                    send_item(hce_pkg::ACTION_END, 8'($urandom), 4'd0, 64'd0);
                    sent++;
                end else begin
                    // A whole message; a quarter of them are sized to end on a chunk boundary.
                    if ($urandom_range(99) < 25) begin
                        len = eff * int'($urandom_range(1, 2));
                    end else begin
                        len = $urandom_range(0, eff + eff / 2 + 2);
                    end
                    repeat (len) send_item(hce_pkg::ACTION_BYTE, 8'($urandom), 4'd0, 64'd0);
                    send_item(hce_pkg::ACTION_END, 8'($urandom), 4'd0, 64'd0);
                    sent += len + 1;
                end
            end
        end
        calm = 1'b0;

        in_if.valid = 1'b0;
        while (pending_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver side. It stalls at random, except in the calm stretch, and once
    // holds off for a long time so that the output register and then the
    // input channel back up while the sender keeps offering items.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
                hold_done    = 1'b1;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_if.ready = calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every output transfer is matched against the oldest owed byte.
    always @(posedge i_clk) begin
        t_enc_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected output byte, expected none, actual %02h last %0b",
                         $time, out_if.out_byte, out_if.last);
                fault_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (out_if.out_byte !== want.code) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.code, out_if.out_byte);
                    fault_cnt++;
                end
                if (out_if.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, out_if.last);
                    fault_cnt++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/hce_pkg.sv
design/hce_stream_if.sv
design/hce_buffer.sv
design/hce_sequencer.sv
design/http_chunked_encoder.sv
design/hce_checker.sv
sim/http_chunked_encoder_tb.sv
